// ===== hw/rtl/rfla_pkg.sv =====
`timescale 1ns / 1ps

package rfla_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int LINE_BUF_DEF   = 256;
  localparam int MAX_RESULTS    = 32;

  localparam int BYTE_W      = 8;
  localparam int LIMIT_W     = 13;
  localparam int LINE_LEN_W  = 9;
  localparam int DROP_W      = 32;
  localparam int WORD_W      = 64;
  localparam int WBYTES_W    = 4;
  localparam int OUT_PAYLOAD_W = WORD_W + WBYTES_W + LINE_LEN_W + DROP_W;
  localparam int OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(256);
  localparam logic [BYTE_W-1:0]  NEWLINE_CHAR = 8'h0A;

  // command codes carried on the input tuser bit
  localparam logic CMD_RX      = 1'b0;
  localparam logic CMD_SERVICE = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_DRAIN   = 5'b00010,
    ST_EMIT_RD = 5'b00100,
    ST_EMIT_LD = 5'b01000,
    ST_NOLINE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic push_byte;
    logic consume;
    logic begin_line;
    logic load_word;
    logic load_noline;
    logic next_word;
  } dp_cmd_t;

  typedef struct packed {
    logic ring_empty;
    logic line_done;
    logic word_last;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/rfla_ram.sv =====
`timescale 1ns / 1ps

module rfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rfla_ctrl.sv =====
`timescale 1ns / 1ps

module rfla_ctrl import rfla_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_axis_tvalid,
  output logic    s_axis_tready,
  input  logic    s_axis_tuser,
  input  dp_sts_t sts,
  output dp_cmd_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    ctl           = '0;
    s_axis_tready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tuser == CMD_SERVICE) begin
            state_next = ST_DRAIN;
          end else begin
            ctl.push_byte = 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (sts.ring_empty) begin
          state_next = ST_NOLINE;
        end else begin
          ctl.consume = 1'b1;
          if (sts.line_done) begin
            ctl.begin_line = 1'b1;
            state_next     = ST_EMIT_RD;
          end
        end
      end
      // line store read is registered
      ST_EMIT_RD: begin
        state_next = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts.out_free) begin
          ctl.load_word = 1'b1;
          if (sts.word_last) begin
            state_next = ST_IDLE;
          end else begin
            ctl.next_word = 1'b1;
            state_next    = ST_EMIT_RD;
          end
        end
      end
      ST_NOLINE: begin
        if (sts.out_free) begin
          ctl.load_noline = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rfla_dp.sv =====
`timescale 1ns / 1ps

module rfla_dp import rfla_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int LINE_BUF   = LINE_BUF_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [BYTE_W-1:0]      in_byte,
  input  dp_cmd_t                ctl,
  output dp_sts_t                sts,
  input  logic                   accept_limit_we,
  input  logic [LIMIT_W-1:0]     accept_limit_wdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int FILL_W  = $clog2(LINE_BUF);
  localparam int ROWS    = (LINE_BUF + 7) / 8;
  localparam int ROW_AW  = $clog2(ROWS);
  localparam int WORDS_W = ROW_AW + 1;

  logic [RING_AW-1:0]    write_pos, read_pos, wp_inc, rp_inc, ring_raddr;
  logic [DROP_W-1:0]     dropped_count;
  logic [FILL_W-1:0]     fill_count;
  logic                  discarding;
  logic [LIMIT_W-1:0]    accept_limit;
  logic [WORD_W-1:0]     asm_word, merged_word;
  logic [FILL_W-1:0]     line_n;
  logic [WORDS_W-1:0]    line_words, words_clamped;
  logic [FILL_W:0]       words_raw;
  logic [ROW_AW-1:0]     word_idx;
  logic [BYTE_W-1:0]     ring_rdata;
  logic [WORD_W-1:0]     line_rdata, masked_word;
  logic                  ring_full, ring_we, line_we, is_nl, fill_at_end;
  logic [FILL_W-1:0]     remain;
  logic [WBYTES_W-1:0]   word_cnt;

  logic [WORD_W-1:0]     out_word;
  logic [WBYTES_W-1:0]   out_bytes;
  logic [LINE_LEN_W-1:0] out_len;
  logic [DROP_W-1:0]     out_drop;
  logic                  out_last, out_nl;

  // ring pointers wrap at any depth, not only powers of two
  assign wp_inc = (write_pos == RING_AW'(RING_DEPTH - 1)) ? '0 : write_pos + 1'b1;
  assign rp_inc = (read_pos == RING_AW'(RING_DEPTH - 1)) ? '0 : read_pos + 1'b1;

  assign ring_full  = (wp_inc == read_pos);
  assign ring_we    = ctl.push_byte && !ring_full;
  // read ahead so the next byte is ready on the cycle after a consume
  assign ring_raddr = ctl.consume ? rp_inc : read_pos;

  rfla_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_pos),
    .wdata (in_byte),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign is_nl       = (ring_rdata == NEWLINE_CHAR);
  assign fill_at_end = (fill_count == FILL_W'(LINE_BUF - 1));
  assign line_we     = ctl.consume && !is_nl && !discarding && !fill_at_end;

  // line store holds whole 8-byte rows; the current row is kept in asm_word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      merged_word[i*8 +: 8] = (3'(i) == fill_count[2:0]) ? ring_rdata : asm_word[i*8 +: 8];
    end
  end

  rfla_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (ROW_AW'(fill_count >> 3)),
    .wdata (merged_word),
    .raddr (word_idx),
    .rdata (line_rdata)
  );

  always_comb begin
    words_raw = ({1'b0, fill_count} + (FILL_W + 1)'(7)) >> 3;
    if (32'(words_raw) > MAX_RESULTS) begin
      words_clamped = WORDS_W'(MAX_RESULTS);
    end else begin
      words_clamped = WORDS_W'(words_raw);
    end
  end

  always_comb begin
    remain   = line_n - FILL_W'({word_idx, 3'b000});
    word_cnt = (remain >= FILL_W'(8)) ? WBYTES_W'(8) : WBYTES_W'(remain);
    for (int i = 0; i < 8; i++) begin
      masked_word[i*8 +: 8] = (WBYTES_W'(i) < word_cnt) ? line_rdata[i*8 +: 8] : 8'h00;
    end
  end

  assign sts.ring_empty = (read_pos == write_pos);
  assign sts.line_done  = is_nl && !discarding && (fill_count != '0) &&
                          (LIMIT_W'(fill_count) < accept_limit);
  assign sts.word_last  = ((WORDS_W'(word_idx) + WORDS_W'(1)) == line_words);
  assign sts.out_free   = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos     <= '0;
      read_pos      <= '0;
      dropped_count <= '0;
      fill_count    <= '0;
      discarding    <= 1'b0;
      accept_limit  <= LIMIT_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept_limit_we) begin
        accept_limit <= accept_limit_wdata;
      end
      if (ctl.push_byte) begin
        if (ring_full) begin
          dropped_count <= dropped_count + 1'b1;
        end else begin
          write_pos <= wp_inc;
        end
      end
      if (ctl.consume) begin
        read_pos <= rp_inc;
        if (is_nl) begin
          fill_count <= '0;
          discarding <= 1'b0;
        end else if (!discarding) begin
          if (fill_at_end) begin
            discarding <= 1'b1;
            fill_count <= '0;
          end else begin
            fill_count <= fill_count + 1'b1;
          end
        end
      end
      if (ctl.load_word || ctl.load_noline) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      asm_word <= merged_word;
    end
    if (ctl.begin_line) begin
      line_n     <= fill_count;
      line_words <= words_clamped;
      word_idx   <= '0;
    end
    if (ctl.next_word) begin
      word_idx <= word_idx + 1'b1;
    end
    if (ctl.load_word) begin
      out_word  <= masked_word;
      out_bytes <= word_cnt;
      out_len   <= LINE_LEN_W'(line_n);
      out_drop  <= dropped_count;
      out_last  <= sts.word_last;
      out_nl    <= 1'b0;
    end else if (ctl.load_noline) begin
      out_word  <= '0;
      out_bytes <= '0;
      out_len   <= '0;
      out_drop  <= dropped_count;
      out_last  <= 1'b1;
      out_nl    <= 1'b1;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W - OUT_PAYLOAD_W)'(0), out_drop, out_len, out_bytes, out_word};
  assign m_axis_tuser = out_nl;
  assign m_axis_tlast = out_last;

endmodule

// ===== hw/rtl/rx_fifo_line_assembler.sv =====
// receive request: next request accepted on the following cycle
// service request: ring bytes drained in turn until a line ends (line store written
//   as it goes), then for each emitted word a row read and a load into the output
//   register, or a check that spots an empty ring and a load of the no-line result;
//   slower if the sink stalls
// reset (rst, synchronous): ring empty, overrun count zero, limit 256, output idle;
//   ring and line stores are not cleared
`timescale 1ns / 1ps

module rx_fifo_line_assembler import rfla_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int LINE_BUF   = LINE_BUF_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,        // [7:0] rx_byte
  input  logic                   s_axis_tuser,        // [0] cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [63:0] line_word, [67:64] word_bytes, [76:68] line_length,
  // [108:77] overrun_total, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,        // [0] no_line
  output logic                   m_axis_tlast,        // last_word
  input  logic                   accept_limit_we,
  input  logic [LIMIT_W-1:0]     accept_limit_wdata
);

  dp_cmd_t ctl;
  dp_sts_t sts;

  rfla_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .sts           (sts),
    .ctl           (ctl)
  );

  rfla_dp #(
    .RING_DEPTH (RING_DEPTH),
    .LINE_BUF   (LINE_BUF)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .in_byte            (s_axis_tdata),
    .ctl                (ctl),
    .sts                (sts),
    .accept_limit_we    (accept_limit_we),
    .accept_limit_wdata (accept_limit_wdata),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tuser       (m_axis_tuser),
    .m_axis_tlast       (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/rfla_checker.sv =====
`timescale 1ns / 1ps

module rfla_checker import rfla_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   s_axis_tuser,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // a no-line result is final and carries no bytes and no length
  a_noline_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[67:64] == 4'd0) &&
    (m_axis_tdata[76:68] == 9'd0) && (m_axis_tdata[63:0] == 64'd0))
    else $error("malformed no-line result");

  // a line word carries one to eight bytes
  a_word_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[67:64] != 4'd0) &&
    (m_axis_tdata[67:64] <= 4'd8))
    else $error("bad byte count on line word");

  // a service request occupies the block, so no request is taken right after it
  a_service_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_SERVICE) |=> !s_axis_tready)
    else $error("request accepted during service");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after reset");

endmodule

bind rx_fifo_line_assembler rfla_checker u_rfla_checker (.*);
